[rtl/accel_motion_still_detector_core_defines.svh]
// Assertion macros used by the core RTL file.
`ifndef ACCEL_MOTION_STILL_DETECTOR_CORE_DEFINES_SVH
`define ACCEL_MOTION_STILL_DETECTOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge, suspended while reset is asserted.
`define AMSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Property checked on every rising edge, reset included.
`define AMSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AMSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define AMSD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[rtl/amsd_pkg.sv]
package amsd_pkg;

	localparam int unsigned AXIS_W   = 16;
	localparam int unsigned SUM_W    = 18;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		ST_UNKNOWN = 2'd0,
		ST_MOVING  = 2'd1,
		ST_STILL   = 2'd2
	} motion_state_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOVE_TOTAL = 3'd0,
		REG_MOVE_PEAK  = 3'd1,
		REG_CALM_TOTAL = 3'd2,
		REG_CALM_PEAK  = 3'd3,
		REG_STILL_WIN  = 3'd4
	} cfg_reg_t;

	localparam logic [SUM_W-1:0]  RST_MOVE_TOTAL = 18'd60;
	localparam logic [AXIS_W-1:0] RST_MOVE_PEAK  = 16'd25;
	localparam logic [SUM_W-1:0]  RST_CALM_TOTAL = 18'd20;
	localparam logic [AXIS_W-1:0] RST_CALM_PEAK  = 16'd8;
	localparam logic [TIME_W-1:0] RST_STILL_WIN  = 32'd2000;

	typedef struct packed {
		logic [SUM_W-1:0]  move_total;
		logic [AXIS_W-1:0] move_peak;
		logic [SUM_W-1:0]  calm_total;
		logic [AXIS_W-1:0] calm_peak;
		logic [TIME_W-1:0] still_win;
	} cfg_t;

	typedef struct packed {
		logic                     req_type;
		logic signed [AXIS_W-1:0] x;
		logic signed [AXIS_W-1:0] y;
		logic signed [AXIS_W-1:0] z;
		logic [TIME_W-1:0]        t;
	} item_t;

	typedef struct packed {
		logic                     have_prev;
		logic signed [AXIS_W-1:0] prev_x;
		logic signed [AXIS_W-1:0] prev_y;
		logic signed [AXIS_W-1:0] prev_z;
		logic                     quiet_running;
		logic [TIME_W-1:0]        quiet_start;
		motion_state_t            state;
	} track_t;

	typedef struct packed {
		logic              motion_event;
		logic              no_motion_event;
		motion_state_t     state;
		logic [SUM_W-1:0]  delta_total;
		logic [AXIS_W-1:0] max_delta;
		logic [TIME_W-1:0] quiet_ms;
	} result_t;

	localparam track_t TRACK_CLEAR = '{
		have_prev: 1'b0, prev_x: '0, prev_y: '0, prev_z: '0,
		quiet_running: 1'b0, quiet_start: '0, state: ST_UNKNOWN
	};

	// Absolute difference of two signed axis values; always fits the axis width.
	function automatic logic [AXIS_W-1:0] abs_diff(logic signed [AXIS_W-1:0] a,
			logic signed [AXIS_W-1:0] b);
		logic signed [AXIS_W:0] d;
		logic [AXIS_W:0] m;
		d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
		m = d[AXIS_W] ? (~d + 1'b1) : d;
		return m[AXIS_W-1:0];
	endfunction

endpackage

[rtl/amsd_cfg_regs.sv]
module amsd_cfg_regs
	import amsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.move_total <= RST_MOVE_TOTAL;
			cfg_q.move_peak  <= RST_MOVE_PEAK;
			cfg_q.calm_total <= RST_CALM_TOTAL;
			cfg_q.calm_peak  <= RST_CALM_PEAK;
			cfg_q.still_win  <= RST_STILL_WIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MOVE_TOTAL: cfg_q.move_total <= cfg_data[SUM_W-1:0];
				REG_MOVE_PEAK:  cfg_q.move_peak  <= cfg_data[AXIS_W-1:0];
				REG_CALM_TOTAL: cfg_q.calm_total <= cfg_data[SUM_W-1:0];
				REG_CALM_PEAK:  cfg_q.calm_peak  <= cfg_data[AXIS_W-1:0];
				REG_STILL_WIN:  cfg_q.still_win  <= cfg_data[TIME_W-1:0];
				default: ; // drop writes to unmapped indices
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/amsd_classify.sv]
module amsd_classify
	import amsd_pkg::*;
(
	input  item_t   item,
	input  track_t  cur,
	input  cfg_t    cfg,
	output track_t  nxt,
	output result_t res
);

	logic [AXIS_W-1:0] dx, dy, dz, mx_xy, mx;
	logic [SUM_W-1:0]  sum;
	logic [TIME_W-1:0] start, elapsed;
	logic              moving, quiet_now;

	assign dx    = abs_diff(item.x, cur.prev_x);
	assign dy    = abs_diff(item.y, cur.prev_y);
	assign dz    = abs_diff(item.z, cur.prev_z);
	assign sum   = SUM_W'(dx) + SUM_W'(dy) + SUM_W'(dz);
	assign mx_xy = (dy > dx) ? dy : dx;
	assign mx    = (dz > mx_xy) ? dz : mx_xy;

	// motion wins where both tests pass
	assign moving    = (sum >= cfg.move_total) || (mx >= cfg.move_peak);
	assign quiet_now = (sum <= cfg.calm_total) && (mx <= cfg.calm_peak);

	assign start   = cur.quiet_running ? cur.quiet_start : item.t;
	assign elapsed = item.t - start;

	always_comb begin
		nxt                 = cur;
		res.motion_event    = 1'b0;
		res.no_motion_event = 1'b0;
		res.delta_total     = '0;
		res.max_delta       = '0;
		res.quiet_ms        = '0;
		if (item.req_type) begin
			nxt = TRACK_CLEAR;
		end else if (item.t == '0) begin
			// invalid time stamp: hold everything
		end else if (!cur.have_prev) begin
			nxt.have_prev     = 1'b1;
			nxt.prev_x        = item.x;
			nxt.prev_y        = item.y;
			nxt.prev_z        = item.z;
			nxt.quiet_running = 1'b1;
			nxt.quiet_start   = item.t;
		end else begin
			res.delta_total = sum;
			res.max_delta   = mx;
			nxt.prev_x      = item.x;
			nxt.prev_y      = item.y;
			nxt.prev_z      = item.z;
			if (moving) begin
				nxt.quiet_running = 1'b0;
				nxt.quiet_start   = '0;
				if (cur.state != ST_MOVING) begin
					nxt.state        = ST_MOVING;
					res.motion_event = 1'b1;
				end
			end else if (!quiet_now) begin
				nxt.quiet_running = 1'b0;
				nxt.quiet_start   = '0;
				if (cur.state == ST_STILL) begin
					nxt.state = ST_UNKNOWN;
				end
			end else begin
				nxt.quiet_running = 1'b1;
				nxt.quiet_start   = start;
				if (cur.state != ST_STILL && elapsed >= cfg.still_win) begin
					nxt.state           = ST_STILL;
					res.no_motion_event = 1'b1;
					res.quiet_ms        = elapsed;
				end
			end
		end
		res.state = nxt.state;
	end

endmodule

[rtl/accel_motion_still_detector_core.sv]
// Accelerometer activity / inactivity classifier.
// Input channel (in_valid/in_ready) carries one transaction per sample: req_type
// selects a sample (0) or a classifier reset (1); accel_x/y/z are signed mg and
// time_ms the sample time, zero marking a sample to ignore.
// Output channel (out_valid/out_ready) returns exactly one result per input
// transaction, in order: motion and no-motion events, the state after the
// sample, the delta sum, the largest axis delta and the quiet time.
// An accepted item sits in the input register, then the classification logic
// feeds the result register, which drives out_valid and the result outputs.
// Throughput is one transaction per cycle while out_ready is high; classifier state
// updates as an item leaves the input register, so the next item sees it at once.
// When the receiver stalls, the result register holds and the input register
// fills; in_ready drops when both hold a transaction and out_ready is low.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge; the user must make them with no transaction in flight (not enforced).
// Asynchronous reset empties both registers, clears the classifier state and
// loads the threshold registers with their defaults.
`include "accel_motion_still_detector_core_defines.svh"
module accel_motion_still_detector_core
	import amsd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  req_type,
	input  logic signed [AXIS_W-1:0] accel_x,
	input  logic signed [AXIS_W-1:0] accel_y,
	input  logic signed [AXIS_W-1:0] accel_z,
	input  logic [TIME_W-1:0]     time_ms,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  motion_event,
	output logic                  no_motion_event,
	output logic [1:0]            motion_state,
	output logic [SUM_W-1:0]      delta_total,
	output logic [AXIS_W-1:0]     peak_delta,
	output logic [TIME_W-1:0]     quiet_ms
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res;
	track_t  track_q;
	track_t  track_nxt;
	logic    adv_s1;
	logic    in_acc;

	amsd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	amsd_classify u_classify (
		.item (item_s1),
		.cur  (track_q),
		.cfg  (cfg),
		.nxt  (track_nxt),
		.res  (res)
	);

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			track_q  <= TRACK_CLEAR;
		end else begin
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				track_q  <= track_nxt;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.req_type <= req_type;
			item_s1.x        <= accel_x;
			item_s1.y        <= accel_y;
			item_s1.z        <= accel_z;
			item_s1.t        <= time_ms;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign out_valid       = valid_s2;
	assign motion_event    = res_s2.motion_event;
	assign no_motion_event = res_s2.no_motion_event;
	assign motion_state    = res_s2.state;
	assign delta_total     = res_s2.delta_total;
	assign peak_delta      = res_s2.max_delta;
	assign quiet_ms        = res_s2.quiet_ms;

	`AMSD_ASSERT(a_ready_when_out_empty, clk, arst_n, !valid_s2 |-> in_ready, "in_ready low with empty result register")
	`AMSD_ASSERT(a_s1_reaches_s2, clk, arst_n, adv_s1 |=> valid_s2, "advanced item missing from result register")
	`AMSD_ASSERT(a_reset_req_clears, clk, arst_n, (adv_s1 && item_s1.req_type) |=> (!track_q.have_prev && track_q.state == ST_UNKNOWN && !track_q.quiet_running), "reset request left classifier state")
	`AMSD_ASSERT(a_quiet_only_with_event, clk, arst_n, (valid_s2 && res_s2.quiet_ms != '0) |-> (res_s2.no_motion_event && res_s2.state == ST_STILL), "quiet time reported without no-motion event")
	`AMSD_ASSERT(a_events_exclusive, clk, arst_n, !(valid_s2 && res_s2.motion_event && res_s2.no_motion_event), "both events raised together")
	`AMSD_ASSERT_ALWAYS(a_reset_empties_output, clk, !arst_n |=> !out_valid, "result valid straight after reset")

endmodule
